// ===== design/assert_macros.svh =====
// concurrent assertion helpers, empty when synthesised
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_SAME(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/hsfc_pkg.sv =====
`timescale 1ns / 1ps

package hsfc_pkg;

    localparam logic [7:0]         CRC_INIT        = 8'hFF;
    localparam logic [7:0]         CRC_POLY        = 8'h31;
    localparam logic [3:0]         RETRY_LIMIT_RST = 4'd4;
    localparam logic [14:0]        TEMP_SCALE      = 15'd17500;
    localparam logic [13:0]        HUM_SCALE       = 14'd10000;
    localparam logic signed [17:0] TEMP_OFFSET     = 18'sd4500;
    localparam logic signed [17:0] TEMP_INVALID    = -18'sd99900;
    localparam logic signed [14:0] HUM_INVALID     = -15'sd100;
    localparam logic [16:0]        FULL_SCALE      = 17'd65535;

    typedef enum logic [1:0] {
        ST_DATA  = 2'd0,
        ST_RETRY = 2'd1,
        ST_LIMIT = 2'd2
    } t_status;

    typedef enum logic [5:0] {
        POS_T_MSB = 6'b000001,
        POS_T_LSB = 6'b000010,
        POS_T_CRC = 6'b000100,
        POS_H_MSB = 6'b001000,
        POS_H_LSB = 6'b010000,
        POS_H_CRC = 6'b100000
    } t_pos;

    // crc-8, msb first, no final xor
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== design/humidity_sensor_frame_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Checks the six bytes of a temperature/humidity sensor frame and scales the readings.
// Slave stream: one received byte per request, in the order temperature msb, lsb,
// crc, humidity msb, lsb, crc. Each word is checked with crc-8 (poly 0x31, init 0xff).
// Master stream: one request per frame, issued after its sixth byte, carrying the
// status, the valid flag, temperature and humidity in hundredths, and the retry count.
// Configuration: i_cfg_wen with i_cfg_wdata sets the retry limit (reset value 4).
// Throughput: one byte per cycle unless a stalled receiver has filled the stages;
// the crc update is an unrolled 8-step network and the scaling is one constant
// multiply per word. Pipeline: the result is registered in the crc/multiply stage
// and then in the divide-by-65535 correction stage.
// Reset clears the frame position, crc, retry counter and all valid flags; the
// limit returns to 4. No clearing pass is needed.
// When the receiver stalls, the pending result holds in the output register and
// bytes are still taken until the internal stages are full, then o_s_tready drops.
module humidity_sensor_frame_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // rx_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // temperature_centi, humidity_centi, retries_used
    output logic [2:0]  o_m_tuser,   // frame_status, data_valid
    input  logic        i_cfg_wen,
    input  logic [3:0]  i_cfg_wdata
);

    logic [3:0] r_limit;

    logic       r_in_vld;
    logic [7:0] r_in_byte;

    hsfc_pkg::t_pos r_pos, n_pos;
    logic [7:0]     r_crc, n_crc;
    logic           r_first_ok, n_first_ok;
    logic [15:0]    r_held_t, n_held_t;
    logic [15:0]    r_held_h, n_held_h;
    logic [3:0]     r_retry, n_retry;

    logic              w_final;
    logic              w_fire_a;
    logic              w_rdy_mid;
    logic              w_rdy_out;
    logic              n_ok;
    hsfc_pkg::t_status n_status;

    logic              r_mid_vld;
    logic              r_mid_ok;
    hsfc_pkg::t_status r_mid_status;
    logic [3:0]        r_mid_retries;
    logic [30:0]       r_mid_tprod;
    logic [29:0]       r_mid_hprod;

    logic [16:0] w_t_rem;
    logic [16:0] w_h_rem;
    logic [14:0] w_t_quot;
    logic [13:0] w_h_quot;

    logic              r_out_vld;
    logic              r_out_ok;
    hsfc_pkg::t_status r_out_status;
    logic [3:0]        r_out_retries;
    logic signed [17:0] r_out_temp;
    logic signed [14:0] r_out_hum;

    assign w_rdy_out  = !r_out_vld || i_m_tready;
    assign w_rdy_mid  = !r_mid_vld || w_rdy_out;
    assign w_fire_a   = r_in_vld && (!w_final || w_rdy_mid);
    assign o_s_tready = !r_in_vld || w_fire_a;

    // frame byte handling
    always_comb begin
        n_pos      = r_pos;
        n_crc      = r_crc;
        n_first_ok = r_first_ok;
        n_held_t   = r_held_t;
        n_held_h   = r_held_h;
        w_final    = 1'b0;
        unique case (r_pos)
            hsfc_pkg::POS_T_MSB: begin
                n_held_t = {r_held_t[7:0], r_in_byte};
                n_crc    = hsfc_pkg::crc8_byte(r_crc, r_in_byte);
                n_pos    = hsfc_pkg::POS_T_LSB;
            end
            hsfc_pkg::POS_T_LSB: begin
                n_held_t = {r_held_t[7:0], r_in_byte};
                n_crc    = hsfc_pkg::crc8_byte(r_crc, r_in_byte);
                n_pos    = hsfc_pkg::POS_T_CRC;
            end
            hsfc_pkg::POS_T_CRC: begin
                n_first_ok = (r_crc == r_in_byte);
                n_crc      = hsfc_pkg::CRC_INIT;
                n_pos      = hsfc_pkg::POS_H_MSB;
            end
            hsfc_pkg::POS_H_MSB: begin
                n_held_h = {r_held_h[7:0], r_in_byte};
                n_crc    = hsfc_pkg::crc8_byte(r_crc, r_in_byte);
                n_pos    = hsfc_pkg::POS_H_LSB;
            end
            hsfc_pkg::POS_H_LSB: begin
                n_held_h = {r_held_h[7:0], r_in_byte};
                n_crc    = hsfc_pkg::crc8_byte(r_crc, r_in_byte);
                n_pos    = hsfc_pkg::POS_H_CRC;
            end
            default: begin
                w_final    = 1'b1;
                n_crc      = hsfc_pkg::CRC_INIT;
                n_first_ok = 1'b0;
                n_pos      = hsfc_pkg::POS_T_MSB;
            end
        endcase
    end

    assign n_ok = r_first_ok && (r_crc == r_in_byte);

    always_comb begin
        priority if (n_ok) begin
            n_status = hsfc_pkg::ST_DATA;
            n_retry  = 4'd0;
        end else if (r_retry < r_limit) begin
            n_status = hsfc_pkg::ST_RETRY;
            n_retry  = r_retry + 4'd1;
        end else begin
            n_status = hsfc_pkg::ST_LIMIT;
            n_retry  = r_retry;
        end
    end

    // divide by 65535: quotient estimate plus one compare
    assign w_t_rem  = {1'b0, r_mid_tprod[15:0]} + {2'b00, r_mid_tprod[30:16]};
    assign w_h_rem  = {1'b0, r_mid_hprod[15:0]} + {3'b000, r_mid_hprod[29:16]};
    assign w_t_quot = r_mid_tprod[30:16] + {14'd0, (w_t_rem >= hsfc_pkg::FULL_SCALE)};
    assign w_h_quot = r_mid_hprod[29:16] + {13'd0, (w_h_rem >= hsfc_pkg::FULL_SCALE)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit    <= hsfc_pkg::RETRY_LIMIT_RST;
            r_in_vld   <= 1'b0;
            r_pos      <= hsfc_pkg::POS_T_MSB;
            r_crc      <= hsfc_pkg::CRC_INIT;
            r_first_ok <= 1'b0;
            r_held_t   <= 16'd0;
            r_held_h   <= 16'd0;
            r_retry    <= 4'd0;
            r_mid_vld  <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_wen) begin
                r_limit <= i_cfg_wdata;
            end
            if (o_s_tready) begin
                r_in_vld <= i_s_tvalid;
            end
            if (w_fire_a) begin
                r_pos      <= n_pos;
                r_crc      <= n_crc;
                r_first_ok <= n_first_ok;
                r_held_t   <= n_held_t;
                r_held_h   <= n_held_h;
                if (w_final) begin
                    r_retry <= n_retry;
                end
            end
            if (w_rdy_mid) begin
                r_mid_vld <= w_fire_a && w_final;
            end
            if (w_rdy_out) begin
                r_out_vld <= r_mid_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready) begin
            r_in_byte <= i_s_tdata;
        end
        if (w_rdy_mid) begin
            r_mid_ok      <= n_ok;
            r_mid_status  <= n_status;
            r_mid_retries <= n_retry;
            r_mid_tprod   <= {15'd0, r_held_t} * {16'd0, hsfc_pkg::TEMP_SCALE};
            r_mid_hprod   <= {14'd0, r_held_h} * {16'd0, hsfc_pkg::HUM_SCALE};
        end
        if (w_rdy_out && r_mid_vld) begin
            r_out_ok      <= r_mid_ok;
            r_out_status  <= r_mid_status;
            r_out_retries <= r_mid_retries;
            if (r_mid_ok) begin
                r_out_temp <= $signed({3'b000, w_t_quot}) - hsfc_pkg::TEMP_OFFSET;
                r_out_hum  <= $signed({1'b0, w_h_quot});
            end else begin
                r_out_temp <= hsfc_pkg::TEMP_INVALID;
                r_out_hum  <= hsfc_pkg::HUM_INVALID;
            end
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {3'b000, r_out_retries, r_out_hum, r_out_temp};
    assign o_m_tuser  = {r_out_ok, r_out_status};

    `ASSERT_SAME(a_good_frame, i_clk, i_rst_n, o_m_tvalid && r_out_ok,
        r_out_status == hsfc_pkg::ST_DATA && r_out_retries == 4'd0)
    `ASSERT_SAME(a_bad_frame, i_clk, i_rst_n, o_m_tvalid && !r_out_ok,
        r_out_temp == hsfc_pkg::TEMP_INVALID && r_out_hum == hsfc_pkg::HUM_INVALID)
    `ASSERT_SAME(a_retry_count, i_clk, i_rst_n,
        r_mid_vld && r_mid_status == hsfc_pkg::ST_RETRY, r_mid_retries != 4'd0)
    `ASSERT_NEXT(a_frame_wrap, i_clk, i_rst_n, w_fire_a && w_final,
        r_pos == hsfc_pkg::POS_T_MSB && r_crc == hsfc_pkg::CRC_INIT && r_mid_vld)

endmodule
